// File: src/simrg_pkg.sv
// Shared widths, types and constants for the sorted interval merger.
// Used by simrg_merge_unit, simrg_result_fifo and sorted_interval_merger_core.
package simrg_pkg;

   localparam int OFFSET_BITS = 48;
   localparam int SIZE_BITS = OFFSET_BITS + 1;
   localparam int REQ_DATA_BITS = ((2 * OFFSET_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((OFFSET_BITS + SIZE_BITS + 7) / 8) * 8;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [OFFSET_BITS-1:0] merged_offset;
      logic [SIZE_BITS-1:0] merged_length;
      logic list_done;
      logic order_error;
   } result_type;

   // Up to two results produced by one segment, in delivery order.
   typedef struct packed {
      logic [1:0] num;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic [CNT_BITS-1:0] count;
      logic room_for_two;
   } fifo_status_type;

endpackage

// File: src/simrg_merge_unit.sv
// Per-list merge state and the combinational merge step for one segment.
// Depends on simrg_pkg.
module simrg_merge_unit (
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  logic [simrg_pkg::OFFSET_BITS-1:0] seg_offset,
   input  logic [simrg_pkg::OFFSET_BITS-1:0] seg_length,
   input  logic list_last,
   output simrg_pkg::push_type push
);

   logic pending_valid_ff, pending_valid_in;
   logic [simrg_pkg::OFFSET_BITS-1:0] pending_start_ff, pending_start_in;
   logic [simrg_pkg::SIZE_BITS-1:0] pending_size_ff, pending_size_in;
   logic [simrg_pkg::OFFSET_BITS-1:0] previous_start_ff, previous_start_in;
   logic merge_stopped_ff, merge_stopped_in;
   logic list_failed_ff, list_failed_in;

   logic [simrg_pkg::SIZE_BITS-1:0] off_wide;
   logic [simrg_pkg::SIZE_BITS-1:0] len_wide;
   logic [simrg_pkg::SIZE_BITS-1:0] pending_end;
   logic [simrg_pkg::SIZE_BITS-1:0] seg_end;
   logic [simrg_pkg::SIZE_BITS-1:0] new_end;

   assign off_wide = {1'b0, seg_offset};
   assign len_wide = {1'b0, seg_length};
   assign pending_end = {1'b0, pending_start_ff} + pending_size_ff;
   assign seg_end = off_wide + len_wide;
   assign new_end = (seg_end < pending_end) ? pending_end : seg_end;

   always_comb begin
      pending_valid_in = pending_valid_ff;
      pending_start_in = pending_start_ff;
      pending_size_in = pending_size_ff;
      previous_start_in = previous_start_ff;
      merge_stopped_in = merge_stopped_ff;
      list_failed_in = list_failed_ff;
      push = '0;

      if (list_failed_ff) begin
         // Rejected list: drop items up to and including its last one.
         if (list_last) begin
            list_failed_in = 1'b0;
         end
      end else if (pending_valid_ff && (seg_offset < previous_start_ff)) begin
         push.num = 2'd1;
         push.first.list_done = 1'b1;
         push.first.order_error = 1'b1;
         pending_valid_in = 1'b0;
         pending_start_in = '0;
         pending_size_in = '0;
         previous_start_in = '0;
         merge_stopped_in = 1'b0;
         list_failed_in = !list_last;
      end else begin
         previous_start_in = seg_offset;
         if (!pending_valid_ff) begin
            pending_valid_in = 1'b1;
            pending_start_in = seg_offset;
            pending_size_in = len_wide;
            merge_stopped_in = (seg_length == '0);
         end else if (!merge_stopped_ff) begin
            if (pending_end >= off_wide) begin
               if (seg_length != '0) begin
                  pending_size_in = new_end - {1'b0, pending_start_ff};
               end else begin
                  pending_size_in = '0;
                  merge_stopped_in = 1'b1;
               end
            end else begin
               push.num = 2'd1;
               push.first.merged_offset = pending_start_ff;
               push.first.merged_length = pending_size_ff;
               pending_start_in = seg_offset;
               pending_size_in = len_wide;
               merge_stopped_in = (seg_length == '0);
            end
         end

         if (list_last) begin
            if (push.num == 2'd0) begin
               push.first.merged_offset = pending_start_in;
               push.first.merged_length = pending_size_in;
               push.first.list_done = 1'b1;
            end else begin
               push.second.merged_offset = pending_start_in;
               push.second.merged_length = pending_size_in;
               push.second.list_done = 1'b1;
            end
            push.num = push.num + 2'd1;
            pending_valid_in = 1'b0;
            pending_start_in = '0;
            pending_size_in = '0;
            previous_start_in = '0;
            merge_stopped_in = 1'b0;
         end
      end

      if (!step) begin
         push.num = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_valid_ff <= 1'b0;
         pending_start_ff <= '0;
         pending_size_ff <= '0;
         previous_start_ff <= '0;
         merge_stopped_ff <= 1'b0;
         list_failed_ff <= 1'b0;
      end else if (step) begin
         pending_valid_ff <= pending_valid_in;
         pending_start_ff <= pending_start_in;
         pending_size_ff <= pending_size_in;
         previous_start_ff <= previous_start_in;
         merge_stopped_ff <= merge_stopped_in;
         list_failed_ff <= list_failed_in;
      end
   end

endmodule

// File: src/simrg_result_fifo.sv
// Small result queue that takes up to two results per cycle and gives one.
// Depends on simrg_pkg.
module simrg_result_fifo (
   input  logic clock,
   input  logic reset,
   input  simrg_pkg::push_type push,
   input  logic pop,
   output logic out_valid,
   output simrg_pkg::result_type out_result,
   output simrg_pkg::fifo_status_type status
);

   simrg_pkg::result_type mem_ff [simrg_pkg::FIFO_DEPTH];
   logic [simrg_pkg::PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [simrg_pkg::CNT_BITS-1:0] count_ff, count_in;
   logic [simrg_pkg::PTR_BITS-1:0] wr_next;
   logic do_pop;

   assign wr_next = wr_ptr_ff + simrg_pkg::PTR_BITS'(1);
   assign do_pop = pop && (count_ff != '0);
   assign count_in = count_ff + simrg_pkg::CNT_BITS'(push.num)
                     - simrg_pkg::CNT_BITS'(do_pop);

   assign out_valid = (count_ff != '0);
   assign out_result = mem_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.room_for_two =
      (count_ff <= simrg_pkg::CNT_BITS'(simrg_pkg::FIFO_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.num == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + simrg_pkg::PTR_BITS'(push.num);
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + simrg_pkg::PTR_BITS'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

// File: src/sorted_interval_merger_core.sv
// Top level of the sorted interval merger: input register, merge step, result queue.
// Depends on simrg_pkg, simrg_merge_unit and simrg_result_fifo.
//
//   Channel | Direction | Beat contents
//   --------+-----------+---------------------------------------------------------
//   req_    | in        | one segment (offset, length), tlast = last of the list
//   rsp_    | out       | one merged segment, tlast = last of list, tuser = error
//
// A segment is accepted into an input register; once it is held there and the queue has
// room for two results, the merge step updates the per-list state and writes zero, one
// or two results into a four-entry result queue, from which a result leaves on rsp_.
// A new segment is accepted every cycle while the queue has room for two results,
// so the input side runs at one segment per cycle; a segment that yields two results
// needs two output beats, and the rsp_ side sets the long-run pace then.
// A stall on rsp_ fills the queue and then holds the input register, which drops
// req_tready; nothing in flight is lost. Synchronous reset clears the list state,
// the input register and the queue.
module sorted_interval_merger_core (
   input  logic clock,
   input  logic reset,

   input  logic req_tvalid,
   output logic req_tready,
   // [OFFSET_BITS-1:0] seg_offset, [2*OFFSET_BITS-1:OFFSET_BITS] seg_length,
   // zero padded to whole bytes above.
   input  logic [simrg_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic req_tlast,

   output logic rsp_tvalid,
   input  logic rsp_tready,
   // [OFFSET_BITS-1:0] merged_offset, then SIZE_BITS of merged_length,
   // zero padded to whole bytes above.
   output logic [simrg_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // [0] order_error
   output logic rsp_tuser,
   output logic rsp_tlast
);

   // Input register holding one accepted segment.
   logic in_valid_ff, in_valid_in;
   logic [simrg_pkg::OFFSET_BITS-1:0] in_offset_ff;
   logic [simrg_pkg::OFFSET_BITS-1:0] in_length_ff;
   logic in_last_ff;

   logic step;
   logic req_fire;
   simrg_pkg::push_type push;
   simrg_pkg::result_type out_result;
   simrg_pkg::fifo_status_type fifo_status;

   // The merge step runs when a segment is held and the queue can absorb the worst
   // case of two results; the decision uses only registered state.
   assign step = in_valid_ff && fifo_status.room_for_two;
   assign req_tready = !in_valid_ff || step;
   assign req_fire = req_tvalid && req_tready;
   assign in_valid_in = req_fire || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_offset_ff <= req_tdata[simrg_pkg::OFFSET_BITS-1:0];
         in_length_ff <= req_tdata[2*simrg_pkg::OFFSET_BITS-1:simrg_pkg::OFFSET_BITS];
         in_last_ff <= req_tlast;
      end
   end

   simrg_merge_unit u_merge (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .seg_offset (in_offset_ff),
      .seg_length (in_length_ff),
      .list_last  (in_last_ff),
      .push       (push)
   );

   simrg_result_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_result (out_result),
      .status     (fifo_status)
   );

   assign rsp_tdata = simrg_pkg::RSP_DATA_BITS'({out_result.merged_length,
                                                 out_result.merged_offset});
   assign rsp_tuser = out_result.order_error;
   assign rsp_tlast = out_result.list_done;

   // The queue never holds more results than it has entries.
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_status.count <= simrg_pkg::CNT_BITS'(simrg_pkg::FIFO_DEPTH))
      else $error("result queue overflow");

   // An error result closes the list and carries no segment.
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata == '0))
      else $error("malformed order error result");

   // An accepted segment is held in the input register in the next cycle.
   a_accept_held: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> in_valid_ff)
      else $error("accepted segment lost");

   // Two results are written only when the queue had room for both.
   a_two_room: assert property (@(posedge clock) disable iff (reset)
      push.num == 2'd2 |-> fifo_status.room_for_two)
      else $error("double push without room");

endmodule
